FILE: rtl/pish_pkg.sv
// Shared constants and codes for the point-in-shape hit test block.
package pish_pkg;

  // Default sizes
  localparam int MAX_SHAPES_DEF = 32;
  localparam int MAX_COORDS_DEF = 256;
  localparam int COORD_BITS_DEF = 14;

  // Fixed field widths
  localparam int ACT_W  = 2;
  localparam int KIND_W = 3;
  localparam int TAG_W  = 8;
  localparam int QW     = 14;  // query and coordinate port width
  localparam int WW     = 16;  // working width for points
  localparam int MW     = 32;  // multiplier operand width
  localparam int PW     = 64;  // multiplier product width

  // Request actions
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_BEGIN  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_APPEND = 2'd2;
  localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd3;

  // Shape kinds
  localparam logic [KIND_W-1:0] KIND_RECT    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ELLIPSE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CIRCLE  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POLY    = 3'd3;

  // Coordinate counts
  localparam int BOX_N    = 4;
  localparam int CIRCLE_N = 3;
  localparam int POLY_MIN = 6;

endpackage

FILE: rtl/pish_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pish_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/pish_mul.sv
// Shared signed multiplier with a registered product.
module pish_mul (
  input  logic                         clk,
  input  logic signed [pish_pkg::MW-1:0] a,
  input  logic signed [pish_pkg::MW-1:0] b,
  output logic signed [pish_pkg::PW-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

FILE: rtl/point_in_shape_hit_test_unit.sv
// Top level: shape table loader and sequenced point-in-shape query engine.
//
//  channel | ports                                  | direction
//  --------+----------------------------------------+----------
//  in      | in_valid/in_ready, action, kind, tag,  | request
//          | coord_value, query_x, query_y          |
//  out     | out_valid/out_ready, hit, hit_tag,     | result
//          | store_overflow                         |
//
// Clear, begin and append give no result.
// A query walks the shapes in load order: each shape entry is fetched (with the
// next entry's start when another entry follows), its coordinates are fetched one
// at a time, an ellipse uses the shared multiplier and a polygon is tested edge by
// edge, and then the result is posted; the single multiplier and coordinate RAM
// port serialize this work. in_ready is low while a query runs.
// Synchronous active-low reset empties the table; no clearing pass.
// A finished result waits in the output register until out_ready.
module point_in_shape_hit_test_unit #(
  parameter int MAX_SHAPES = pish_pkg::MAX_SHAPES_DEF,
  parameter int MAX_COORDS = pish_pkg::MAX_COORDS_DEF,
  parameter int COORD_BITS = pish_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [pish_pkg::ACT_W-1:0]      in_action,
  input  logic [pish_pkg::KIND_W-1:0]     in_shape_kind,
  input  logic [pish_pkg::TAG_W-1:0]      in_shape_tag,
  input  logic signed [pish_pkg::QW-1:0]  in_coord_value,
  input  logic signed [pish_pkg::QW-1:0]  in_query_x,
  input  logic signed [pish_pkg::QW-1:0]  in_query_y,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_hit,
  output logic [pish_pkg::TAG_W-1:0]      out_hit_tag,
  output logic                            out_store_overflow
);

  localparam int SCW = $clog2(MAX_SHAPES + 1);
  localparam int CCW = $clog2(MAX_COORDS + 1);
  localparam int SIW = (MAX_SHAPES > 1) ? $clog2(MAX_SHAPES) : 1;
  localparam int CIW = (MAX_COORDS > 1) ? $clog2(MAX_COORDS) : 1;
  localparam int KW  = pish_pkg::KIND_W;
  localparam int TW  = pish_pkg::TAG_W;
  localparam int WW  = pish_pkg::WW;
  localparam int MW  = pish_pkg::MW;
  localparam int PW  = pish_pkg::PW;
  localparam int EW  = KW + TW + CCW;

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ENT_A = 4'd1;
  localparam logic [3:0] S_ENT_B = 4'd2;
  localparam logic [3:0] S_ENT_C = 4'd3;
  localparam logic [3:0] S_DISP  = 4'd4;
  localparam logic [3:0] S_CRD_A = 4'd5;
  localparam logic [3:0] S_CRD_B = 4'd6;
  localparam logic [3:0] S_CALC  = 4'd7;
  localparam logic [3:0] S_EDGE  = 4'd8;
  localparam logic [3:0] S_NEXT  = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  logic [3:0]           state_r, state_nxt;
  logic [SCW-1:0]       shape_cnt_r, shape_cnt_nxt;
  logic [CCW-1:0]       coord_cnt_r, coord_cnt_nxt;
  logic                 ovf_r, ovf_nxt;
  logic                 open_r, open_nxt;
  logic signed [WW-1:0] qx_r, qx_nxt, qy_r, qy_nxt;
  logic [SCW-1:0]       idx_r, idx_nxt;
  logic [KW-1:0]        kind_r, kind_nxt;
  logic [TW-1:0]        tag_r, tag_nxt;
  logic [CCW-1:0]       first_r, first_nxt, end_r, end_nxt;
  logic [CCW-1:0]       k_r, k_nxt;
  logic [2:0]           ms_r, ms_nxt;
  logic signed [WW-1:0] p0_r, p0_nxt, p1_r, p1_nxt, p2_r, p2_nxt, p3_r, p3_nxt;
  logic signed [WW-1:0] fx_r, fx_nxt, fy_r, fy_nxt;
  logic                 close_r, close_nxt, par_r, par_nxt, hit_r, hit_nxt;
  logic signed [PW-1:0] t0_r, t0_nxt, t1_r, t1_nxt, t2_r, t2_nxt, t3_r, t3_nxt;
  logic                 res_hit_r, res_hit_nxt;
  logic [TW-1:0]        res_tag_r, res_tag_nxt;
  logic                 out_valid_r, out_valid_nxt, out_hit_r, out_hit_nxt;
  logic [TW-1:0]        out_tag_r, out_tag_nxt;
  logic                 out_ovf_r, out_ovf_nxt;

  logic                 acc;
  logic                 ent_we, crd_we;
  logic [EW-1:0]        ent_rdata;
  logic [COORD_BITS-1:0] crd_rdata;
  logic [SCW-1:0]       idx_inc;
  logic [SIW-1:0]       ent_raddr;
  logic [CCW-1:0]       crd_addr_w;
  logic signed [WW-1:0] crd_val;
  logic [CCW-1:0]       n_w;
  logic                 cnt_ok;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p;

  // Wide views of the working registers
  logic signed [MW-1:0] x_w, y_w, a0, a1, a2, a3;
  logic signed [MW-1:0] rx_d, ry_d, rx_w, ry_w, dx_w, dy_w;
  logic                 y_eq1, y_eq2, x_le2, x_lt1, outside;

  assign acc      = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);

  // Table writes
  assign ent_we = acc && (in_action == pish_pkg::ACT_BEGIN) &&
                  (shape_cnt_r < SCW'(MAX_SHAPES));
  assign crd_we = acc && (in_action == pish_pkg::ACT_APPEND) && open_r &&
                  (coord_cnt_r < CCW'(MAX_COORDS));

  assign idx_inc    = idx_r + SCW'(1);
  assign ent_raddr  = (state_r == S_ENT_B) ? idx_inc[SIW-1:0] : idx_r[SIW-1:0];
  assign crd_addr_w = first_r + k_r;
  assign crd_val    = WW'($signed(crd_rdata));
  assign n_w        = end_r - first_r;

  pish_ram #(.WIDTH(EW), .DEPTH(MAX_SHAPES), .AW(SIW)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (shape_cnt_r[SIW-1:0]),
    .wdata ({in_shape_kind, in_shape_tag, coord_cnt_r}),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  pish_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_COORDS), .AW(CIW)) u_crd_ram (
    .clk   (clk),
    .we    (crd_we),
    .waddr (coord_cnt_r[CIW-1:0]),
    .wdata (in_coord_value[COORD_BITS-1:0]),
    .raddr (crd_addr_w[CIW-1:0]),
    .rdata (crd_rdata)
  );

  pish_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // Operand views and shape geometry
  assign x_w  = MW'(qx_r);
  assign y_w  = MW'(qy_r);
  assign a0   = MW'(p0_r);
  assign a1   = MW'(p1_r);
  assign a2   = MW'(p2_r);
  assign a3   = MW'(p3_r);
  assign rx_d = a0 - a2;
  assign ry_d = a1 - a3;
  assign rx_w = rx_d[MW-1] ? -rx_d : rx_d;
  assign ry_w = ry_d[MW-1] ? -ry_d : ry_d;
  assign dx_w = (x_w <<< 1) - (a0 + a2);
  assign dy_w = (y_w <<< 1) - (a1 + a3);

  // Polygon edge scanline terms: (p0,p1) to (p2,p3)
  assign y_eq1   = (qy_r == p1_r);
  assign y_eq2   = (qy_r == p3_r);
  assign x_le2   = (qx_r <= p2_r);
  assign x_lt1   = (qx_r < p0_r);
  assign outside = ((qy_r < p1_r) && (qy_r < p3_r)) ||
                   ((qy_r > p1_r) && (qy_r > p3_r));

  // Coordinate count check per kind
  always_comb begin
    case (kind_r)
      pish_pkg::KIND_RECT,
      pish_pkg::KIND_ELLIPSE: cnt_ok = (n_w == CCW'(pish_pkg::BOX_N));
      pish_pkg::KIND_CIRCLE:  cnt_ok = (n_w == CCW'(pish_pkg::CIRCLE_N));
      pish_pkg::KIND_POLY:    cnt_ok = !n_w[0] && (n_w >= CCW'(pish_pkg::POLY_MIN));
      default:                cnt_ok = 1'b0;
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    shape_cnt_nxt = shape_cnt_r;
    coord_cnt_nxt = coord_cnt_r;
    ovf_nxt       = ovf_r;
    open_nxt      = open_r;
    qx_nxt        = qx_r;
    qy_nxt        = qy_r;
    idx_nxt       = idx_r;
    kind_nxt      = kind_r;
    tag_nxt       = tag_r;
    first_nxt     = first_r;
    end_nxt       = end_r;
    k_nxt         = k_r;
    ms_nxt        = ms_r;
    p0_nxt        = p0_r;
    p1_nxt        = p1_r;
    p2_nxt        = p2_r;
    p3_nxt        = p3_r;
    fx_nxt        = fx_r;
    fy_nxt        = fy_r;
    close_nxt     = close_r;
    par_nxt       = par_r;
    hit_nxt       = hit_r;
    t0_nxt        = t0_r;
    t1_nxt        = t1_r;
    t2_nxt        = t2_r;
    t3_nxt        = t3_r;
    res_hit_nxt   = res_hit_r;
    res_tag_nxt   = res_tag_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_hit_nxt   = out_hit_r;
    out_tag_nxt   = out_tag_r;
    out_ovf_nxt   = out_ovf_r;
    mul_a         = '0;
    mul_b         = '0;

    case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (in_action)
            pish_pkg::ACT_CLEAR: begin
              shape_cnt_nxt = '0;
              coord_cnt_nxt = '0;
              ovf_nxt       = 1'b0;
              open_nxt      = 1'b0;
            end
            pish_pkg::ACT_BEGIN: begin
              if (ent_we) begin
                shape_cnt_nxt = shape_cnt_r + SCW'(1);
                open_nxt      = 1'b1;
              end else begin
                ovf_nxt  = 1'b1;
                open_nxt = 1'b0;
              end
            end
            pish_pkg::ACT_APPEND: begin
              if (crd_we) begin
                coord_cnt_nxt = coord_cnt_r + CCW'(1);
              end else if (open_r) begin
                ovf_nxt = 1'b1;
              end
            end
            default: begin
              qx_nxt      = WW'(in_query_x);
              qy_nxt      = WW'(in_query_y);
              idx_nxt     = '0;
              res_hit_nxt = 1'b0;
              res_tag_nxt = '0;
              state_nxt   = (shape_cnt_r == '0) ? S_FIN : S_ENT_A;
            end
          endcase
        end
      end

      // Entry fetch: this entry, then the next one's start
      S_ENT_A: state_nxt = S_ENT_B;

      S_ENT_B: begin
        kind_nxt  = ent_rdata[EW-1 -: KW];
        tag_nxt   = ent_rdata[CCW +: TW];
        first_nxt = ent_rdata[CCW-1:0];
        if (idx_inc < shape_cnt_r) begin
          state_nxt = S_ENT_C;
        end else begin
          end_nxt   = coord_cnt_r;
          state_nxt = S_DISP;
        end
      end

      S_ENT_C: begin
        end_nxt   = ent_rdata[CCW-1:0];
        state_nxt = S_DISP;
      end

      S_DISP: begin
        k_nxt     = '0;
        close_nxt = 1'b0;
        par_nxt   = 1'b0;
        hit_nxt   = 1'b0;
        state_nxt = cnt_ok ? S_CRD_A : S_NEXT;
      end

      // Coordinate fetch
      S_CRD_A: state_nxt = S_CRD_B;

      S_CRD_B: begin
        k_nxt = k_r + CCW'(1);
        if (kind_r == pish_pkg::KIND_POLY) begin
          if (!k_r[0]) begin
            p2_nxt    = crd_val;
            state_nxt = S_CRD_A;
          end else begin
            p3_nxt = crd_val;
            if (k_r == CCW'(1)) begin
              p0_nxt    = p2_r;
              p1_nxt    = crd_val;
              fx_nxt    = p2_r;
              fy_nxt    = crd_val;
              state_nxt = S_CRD_A;
            end else begin
              ms_nxt    = '0;
              state_nxt = S_CALC;
            end
          end
        end else begin
          case (k_r[1:0])
            2'd0:    p0_nxt = crd_val;
            2'd1:    p1_nxt = crd_val;
            2'd2:    p2_nxt = crd_val;
            default: p3_nxt = crd_val;
          endcase
          if (k_nxt == n_w) begin
            ms_nxt    = '0;
            state_nxt = S_CALC;
          end else begin
            state_nxt = S_CRD_A;
          end
        end
      end

      // Shape test; ellipses, circles and polygon edges use the shared multiplier
      S_CALC: begin
        ms_nxt = ms_r + 3'd1;
        case (kind_r)
          pish_pkg::KIND_RECT: begin
            hit_nxt   = (p0_r <= qx_r) && (p2_r >= qx_r) &&
                        (p1_r <= qy_r) && (p3_r >= qy_r);
            state_nxt = S_NEXT;
          end

          pish_pkg::KIND_ELLIPSE: begin
            case (ms_r)
              3'd0: begin
                if (rx_w == '0 || ry_w == '0) begin
                  hit_nxt   = 1'b0;
                  state_nxt = S_NEXT;
                end
                mul_a = dx_w;
                mul_b = dx_w;
              end
              3'd1: begin
                mul_a  = dy_w;
                mul_b  = dy_w;
                t0_nxt = mul_p;
              end
              3'd2: begin
                mul_a  = rx_w;
                mul_b  = rx_w;
                t1_nxt = mul_p;
              end
              3'd3: begin
                mul_a  = ry_w;
                mul_b  = ry_w;
                t2_nxt = mul_p;
              end
              3'd4: begin
                mul_a  = $signed(t0_r[MW-1:0]);
                mul_b  = $signed(mul_p[MW-1:0]);
                t3_nxt = mul_p;
              end
              3'd5: begin
                mul_a  = $signed(t1_r[MW-1:0]);
                mul_b  = $signed(t2_r[MW-1:0]);
                t0_nxt = mul_p;
              end
              3'd6: begin
                mul_a  = $signed(t2_r[MW-1:0]);
                mul_b  = $signed(t3_r[MW-1:0]);
                t1_nxt = mul_p;
              end
              default: begin
                hit_nxt   = (t0_r + t1_r) <= mul_p;
                state_nxt = S_NEXT;
              end
            endcase
          end

          pish_pkg::KIND_CIRCLE: begin
            case (ms_r)
              3'd0: begin
                mul_a = a0 - x_w;
                mul_b = a0 - x_w;
              end
              3'd1: begin
                mul_a  = a1 - y_w;
                mul_b  = a1 - y_w;
                t0_nxt = mul_p;
              end
              3'd2: begin
                mul_a  = a2;
                mul_b  = a2;
                t1_nxt = mul_p;
              end
              default: begin
                hit_nxt   = (t0_r + t1_r) <= mul_p;
                state_nxt = S_NEXT;
              end
            endcase
          end

          default: begin
            // Polygon edge with the scanline vertex rules
            case (ms_r)
              3'd0: begin
                mul_a = y_w - a1;
                mul_b = a2 - a0;
                if (p1_r == p3_r) begin
                  state_nxt = S_EDGE;
                end else if (p1_r > p3_r) begin
                  if (y_eq1) begin
                    state_nxt = S_EDGE;
                  end else if (y_eq2 && x_le2) begin
                    par_nxt   = !par_r;
                    state_nxt = S_EDGE;
                  end else if (outside) begin
                    state_nxt = S_EDGE;
                  end
                end else begin
                  if (y_eq1 && x_lt1) begin
                    par_nxt   = !par_r;
                    state_nxt = S_EDGE;
                  end else if (y_eq2 || outside) begin
                    state_nxt = S_EDGE;
                  end
                end
              end
              3'd1: begin
                mul_a  = x_w - a0;
                mul_b  = a3 - a1;
                t0_nxt = mul_p;
              end
              default: begin
                if (p3_r > p1_r) begin
                  par_nxt = par_r ^ (t0_r > mul_p);
                end else begin
                  par_nxt = par_r ^ (t0_r < mul_p);
                end
                state_nxt = S_EDGE;
              end
            endcase
          end
        endcase
      end

      // Polygon: advance to the next edge, closing back to the first vertex
      S_EDGE: begin
        p0_nxt = p2_r;
        p1_nxt = p3_r;
        ms_nxt = '0;
        if (close_r) begin
          hit_nxt   = par_r;
          state_nxt = S_NEXT;
        end else if (k_r == n_w) begin
          p2_nxt    = fx_r;
          p3_nxt    = fy_r;
          close_nxt = 1'b1;
          state_nxt = S_CALC;
        end else begin
          state_nxt = S_CRD_A;
        end
      end

      S_NEXT: begin
        if (hit_r) begin
          res_hit_nxt = 1'b1;
          res_tag_nxt = tag_r;
          state_nxt   = S_FIN;
        end else if (idx_inc == shape_cnt_r) begin
          state_nxt = S_FIN;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_ENT_A;
        end
      end

      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = res_hit_r;
          out_tag_nxt   = res_tag_r;
          out_ovf_nxt   = ovf_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      shape_cnt_r <= '0;
      coord_cnt_r <= '0;
      ovf_r       <= 1'b0;
      open_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      shape_cnt_r <= shape_cnt_nxt;
      coord_cnt_r <= coord_cnt_nxt;
      ovf_r       <= ovf_nxt;
      open_r      <= open_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    qx_r      <= qx_nxt;
    qy_r      <= qy_nxt;
    idx_r     <= idx_nxt;
    kind_r    <= kind_nxt;
    tag_r     <= tag_nxt;
    first_r   <= first_nxt;
    end_r     <= end_nxt;
    k_r       <= k_nxt;
    ms_r      <= ms_nxt;
    p0_r      <= p0_nxt;
    p1_r      <= p1_nxt;
    p2_r      <= p2_nxt;
    p3_r      <= p3_nxt;
    fx_r      <= fx_nxt;
    fy_r      <= fy_nxt;
    close_r   <= close_nxt;
    par_r     <= par_nxt;
    hit_r     <= hit_nxt;
    t0_r      <= t0_nxt;
    t1_r      <= t1_nxt;
    t2_r      <= t2_nxt;
    t3_r      <= t3_nxt;
    res_hit_r <= res_hit_nxt;
    res_tag_r <= res_tag_nxt;
    out_hit_r <= out_hit_nxt;
    out_tag_r <= out_tag_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_hit            = out_hit_r;
  assign out_hit_tag        = out_tag_r;
  assign out_store_overflow = out_ovf_r;

endmodule
